### rtl/dtq_pkg.sv
// dtq_pkg: shared types and codes for the delta timeout queue
// no dependencies; used by every rtl file of the block
package dtq_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int MAX_RESULTS     = 16;

    localparam logic [1:0] MODE_ARM     = 2'd0;
    localparam logic [1:0] MODE_CANCEL  = 2'd1;
    localparam logic [1:0] MODE_ADVANCE = 2'd2;
    localparam logic [1:0] MODE_UNUSED  = 2'd3;

    localparam logic [2:0] ST_EXPIRED   = 3'd0;
    localparam logic [2:0] ST_ARMED     = 3'd1;
    localparam logic [2:0] ST_DROPPED   = 3'd2;
    localparam logic [2:0] ST_CANCELLED = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;
    localparam logic [2:0] ST_NONE      = 3'd5;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] delay_ms;
        logic [7:0]  handler_id;
        logic [15:0] arg_tag;
        logic [31:0] elapsed_ms;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  expired_handler;
        logic [15:0] expired_arg;
        logic        last;
    } t_res;

    typedef struct packed {
        logic [31:0] delta;
        logic [23:0] key;
    } t_entry;

endpackage

### rtl/delta_timeout_queue.sv
// delta_timeout_queue: top level of the sorted delta-list timeout queue
// depends on dtq_pkg, dtq_front, dtq_engine, dtq_resq
//
// Requests (arm, cancel, advance) enter a two-word queue; mode 3 is accepted
// and discarded. One request is worked at a time by a sequencer over a
// single-port entry memory of QUEUE_DEPTH words, one read or write per cycle.
// Arm and cancel scan the entries in order and then move the entries behind
// the insert or removal point, so every live entry is either scanned or
// moved; advance shifts the remaining list down for every expiry popped.
// Results leave through a two-word queue, so up to two requests and two
// results can wait while the sequencer works. No clearing pass runs after
// reset.
module delta_timeout_queue #(
    parameter int QUEUE_DEPTH = dtq_pkg::DEF_QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  dtq_pkg::t_req i_req,
    output logic          empty,
    input  logic          pop,
    output dtq_pkg::t_res o_res
);
    import dtq_pkg::*;

    logic cmd_valid, cmd_take, res_push, res_full;
    t_req cmd;
    t_res res;

    dtq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_req       (i_req),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_take  (cmd_take)
    );

    dtq_engine #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .o_res_push  (res_push),
        .o_res       (res),
        .i_res_full  (res_full)
    );

    dtq_resq u_resq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_res_push (res_push),
        .i_res      (res),
        .o_res_full (res_full),
        .empty      (empty),
        .pop        (pop),
        .o_res      (o_res)
    );

endmodule

### rtl/dtq_front.sv
// dtq_front: two-word request queue that drops unused modes
// depends on dtq_pkg
module dtq_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  dtq_pkg::t_req i_req,
    output logic          o_cmd_valid,
    output dtq_pkg::t_req o_cmd,
    input  logic          i_cmd_take
);
    import dtq_pkg::*;

    t_req       r_slot [2];
    logic [1:0] r_cnt;
    logic       keep;

    assign full        = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_slot[0];
    assign keep        = push && !full && (i_req.mode != MODE_UNUSED);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= r_cnt + {1'b0, keep} - {1'b0, i_cmd_take};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_take) begin
            r_slot[0] <= r_slot[1];
        end
        if (keep) begin
            if (r_cnt == 2'd0 || (r_cnt == 2'd1 && i_cmd_take)) begin
                r_slot[0] <= i_req;
            end else begin
                r_slot[i_cmd_take ? 0 : 1] <= i_req;
            end
        end
    end

endmodule

### rtl/dtq_resq.sv
// dtq_resq: two-word result queue in front of the output ports
// depends on dtq_pkg
module dtq_resq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_res_push,
    input  dtq_pkg::t_res i_res,
    output logic          o_res_full,
    output logic          empty,
    input  logic          pop,
    output dtq_pkg::t_res o_res
);
    import dtq_pkg::*;

    t_res       r_slot [2];
    logic [1:0] r_cnt;
    logic       take;

    assign o_res_full = (r_cnt == 2'd2);
    assign empty      = (r_cnt == 2'd0);
    assign o_res      = r_slot[0];
    assign take       = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= r_cnt + {1'b0, i_res_push} - {1'b0, take};
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_slot[0] <= r_slot[1];
        end
        if (i_res_push) begin
            if (r_cnt == 2'd0 || (r_cnt == 2'd1 && take)) begin
                r_slot[0] <= i_res;
            end else begin
                r_slot[take ? 0 : 1] <= i_res;
            end
        end
    end

endmodule

### rtl/dtq_engine.sv
// dtq_engine: sequencer over the single-port entry memory (arm, cancel, advance)
// depends on dtq_pkg
module dtq_engine #(
    parameter int QUEUE_DEPTH = dtq_pkg::DEF_QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  dtq_pkg::t_req i_cmd,
    output logic          o_cmd_take,
    output logic          o_res_push,
    output dtq_pkg::t_res o_res,
    input  logic          i_res_full
);
    import dtq_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int NW = $clog2(MAX_RESULTS + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);
    localparam logic [NW-1:0] MAX_N    = NW'(MAX_RESULTS);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_ARM_SCAN = 4'd1;
    localparam logic [3:0] S_ARM_CMP  = 4'd2;
    localparam logic [3:0] S_UP       = 4'd3;
    localparam logic [3:0] S_UP_WR    = 4'd4;
    localparam logic [3:0] S_CAN_SCAN = 4'd5;
    localparam logic [3:0] S_CAN_CMP  = 4'd6;
    localparam logic [3:0] S_DN       = 4'd7;
    localparam logic [3:0] S_DN_WR    = 4'd8;
    localparam logic [3:0] S_ADV_HEAD = 4'd9;
    localparam logic [3:0] S_ADV_NEXT = 4'd10;
    localparam logic [3:0] S_ADV_CHK  = 4'd11;

    t_entry r_mem [QUEUE_DEPTH];
    t_entry r_rdata;

    logic [3:0]    r_state, n_state;
    logic [1:0]    r_op, n_op;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_pos, n_pos;
    logic [31:0]   r_rem, n_rem;
    logic [31:0]   r_elapsed, n_elapsed;
    logic [23:0]   r_key, n_key;
    logic [23:0]   r_pend, n_pend;
    logic [NW-1:0] r_n, n_n;

    logic          rd_en, we, emit, take;
    logic [AW-1:0] rd_addr, wr_addr;
    t_entry        wr_data;
    t_res          res;
    logic [31:0]   sat;

    assign sat = (r_rdata.delta > r_elapsed) ? (r_rdata.delta - r_elapsed) : 32'd0;

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_cnt     = r_cnt;
        n_idx     = r_idx;
        n_pos     = r_pos;
        n_rem     = r_rem;
        n_elapsed = r_elapsed;
        n_key     = r_key;
        n_pend    = r_pend;
        n_n       = r_n;
        rd_en     = 1'b0;
        rd_addr   = '0;
        we        = 1'b0;
        wr_addr   = '0;
        wr_data   = r_rdata;
        emit      = 1'b0;
        take      = 1'b0;
        res       = '0;
        res.last  = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    take      = 1'b1;
                    n_op      = i_cmd.mode;
                    n_key     = {i_cmd.handler_id, i_cmd.arg_tag};
                    n_rem     = i_cmd.delay_ms;
                    n_elapsed = i_cmd.elapsed_ms;
                    n_idx     = '0;
                    n_n       = '0;
                    if (i_cmd.mode == MODE_ARM) begin
                        if (r_cnt == FULL_CNT) begin
                            emit       = 1'b1;
                            res.status = ST_DROPPED;
                        end else begin
                            n_state = S_ARM_SCAN;
                        end
                    end else if (i_cmd.mode == MODE_CANCEL) begin
                        n_state = S_CAN_SCAN;
                    end else if (r_cnt == '0) begin
                        emit       = 1'b1;
                        res.status = ST_NONE;
                    end else begin
                        rd_en   = 1'b1;
                        n_state = S_ADV_HEAD;
                    end
                end
            end
            S_ARM_SCAN: begin
                if (r_idx == r_cnt) begin
                    n_pos   = r_idx;
                    n_state = S_UP;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_idx[AW-1:0];
                    n_state = S_ARM_CMP;
                end
            end
            S_ARM_CMP: begin
                if (r_rdata.delta <= r_rem) begin
                    n_rem   = r_rem - r_rdata.delta;
                    n_idx   = r_idx + 1'b1;
                    n_state = S_ARM_SCAN;
                end else begin
                    n_pos   = r_idx;
                    n_idx   = r_cnt;
                    n_state = S_UP;
                end
            end
            S_UP: begin
                if (r_idx == r_pos) begin
                    we         = 1'b1;
                    wr_addr    = r_pos[AW-1:0];
                    wr_data    = '{delta: r_rem, key: r_key};
                    n_cnt      = r_cnt + 1'b1;
                    emit       = 1'b1;
                    res.status = ST_ARMED;
                    n_state    = S_IDLE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(r_idx - 1'b1);
                    n_state = S_UP_WR;
                end
            end
            S_UP_WR: begin
                we      = 1'b1;
                wr_addr = r_idx[AW-1:0];
                if (r_idx - 1'b1 == r_pos) begin
                    wr_data.delta = r_rdata.delta - r_rem;
                end
                n_idx   = r_idx - 1'b1;
                n_state = S_UP;
            end
            S_CAN_SCAN: begin
                if (r_idx == r_cnt) begin
                    emit       = 1'b1;
                    res.status = ST_NOT_FOUND;
                    n_state    = S_IDLE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_idx[AW-1:0];
                    n_state = S_CAN_CMP;
                end
            end
            S_CAN_CMP: begin
                if (r_rdata.key == r_key) begin
                    n_rem   = r_rdata.delta;
                    n_state = S_DN;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_CAN_SCAN;
                end
            end
            S_DN: begin
                if (r_idx + 1'b1 == r_cnt) begin
                    n_cnt = r_cnt - 1'b1;
                    if (r_op == MODE_CANCEL) begin
                        emit       = 1'b1;
                        res.status = ST_CANCELLED;
                        n_state    = S_IDLE;
                    end else begin
                        n_state = S_ADV_NEXT;
                    end
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(r_idx + 1'b1);
                    n_state = S_DN_WR;
                end
            end
            S_DN_WR: begin
                we            = 1'b1;
                wr_addr       = r_idx[AW-1:0];
                wr_data.delta = r_rdata.delta + r_rem;
                n_rem         = '0;
                n_idx         = r_idx + 1'b1;
                n_state       = S_DN;
            end
            S_ADV_HEAD: begin
                we            = 1'b1;
                wr_data.delta = sat;
                if (sat != 32'd0) begin
                    emit       = 1'b1;
                    res.status = ST_NONE;
                    n_state    = S_IDLE;
                end else begin
                    n_pend  = r_rdata.key;
                    n_n     = NW'(1);
                    n_idx   = '0;
                    n_rem   = '0;
                    n_state = S_DN;
                end
            end
            S_ADV_NEXT: begin
                if (r_n == MAX_N || r_cnt == '0) begin
                    emit                = 1'b1;
                    res.status          = ST_EXPIRED;
                    res.expired_handler = r_pend[23:16];
                    res.expired_arg     = r_pend[15:0];
                    n_state             = S_IDLE;
                end else begin
                    rd_en   = 1'b1;
                    n_state = S_ADV_CHK;
                end
            end
            S_ADV_CHK: begin
                emit                = 1'b1;
                res.status          = ST_EXPIRED;
                res.expired_handler = r_pend[23:16];
                res.expired_arg     = r_pend[15:0];
                if (r_rdata.delta == 32'd0) begin
                    res.last = 1'b0;
                    n_pend   = r_rdata.key;
                    n_n      = r_n + 1'b1;
                    n_idx    = '0;
                    n_rem    = '0;
                    n_state  = S_DN;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // hold everything while a result is due and the result queue has no room
        if (emit && i_res_full) begin
            n_state   = r_state;
            n_op      = r_op;
            n_cnt     = r_cnt;
            n_idx     = r_idx;
            n_pos     = r_pos;
            n_rem     = r_rem;
            n_elapsed = r_elapsed;
            n_key     = r_key;
            n_pend    = r_pend;
            n_n       = r_n;
            rd_en     = 1'b0;
            we        = 1'b0;
            take      = 1'b0;
        end
    end

    assign o_cmd_take = take;
    assign o_res_push = emit && !i_res_full;
    assign o_res      = res;

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
        if (we) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_idx     <= n_idx;
        r_pos     <= n_pos;
        r_rem     <= n_rem;
        r_elapsed <= n_elapsed;
        r_key     <= n_key;
        r_pend    <= n_pend;
        r_n       <= n_n;
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FULL_CNT)
        else $error("entry count above depth");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> !i_res_full)
        else $error("result pushed into full queue");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !we)
        else $error("memory written while idle");

    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_take |-> (r_state == S_IDLE) && i_cmd_valid)
        else $error("command taken while busy");

endmodule
